@@ rtl/adcss_pkg.sv @@
package adcss_pkg;

  localparam int TIME_WIDTH       = 32;
  localparam int TEMP_WIDTH       = 16;
  localparam int MAX_CHANNELS_DEF = 8;
  localparam int CFG_W            = 32;
  localparam int CFG_IDX_W        = 3;
  localparam int EV_W             = 3;
  localparam int CH_OUT_W         = 3;
  localparam int PROBE_W          = 4;
  localparam int CNT_CFG_W        = 4;
  localparam int PROBE_SLOTS      = CFG_W / PROBE_W;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CH_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MAP = 3'd4;

  localparam logic [EV_W-1:0] EV_IDLE    = 3'd0;
  localparam logic [EV_W-1:0] EV_STARTED = 3'd1;
  localparam logic [EV_W-1:0] EV_STORED  = 3'd2;
  localparam logic [EV_W-1:0] EV_CLEARED = 3'd3;
  localparam logic [EV_W-1:0] EV_FAILED  = 3'd4;
  localparam logic [EV_W-1:0] EV_READ    = 3'd5;

  typedef struct packed {
    logic                         cmd;
    logic [TIME_WIDTH-1:0]        now;
    logic [PROBE_W-1:0]           probe_sel;
    logic                         start_ok;
    logic                         poll_ok;
    logic                         busy_req;
    logic                         value_ok;
    logic                         convert_ok;
    logic signed [TEMP_WIDTH-1:0] temperature;
  } in_req_t;

  typedef struct packed {
    logic [EV_W-1:0]              event_res;
    logic [CH_OUT_W-1:0]          channel;
    logic                         read_valid;
    logic signed [TEMP_WIDTH-1:0] read_temperature;
  } out_res_t;

  typedef struct packed {
    logic load;
    logic do_svc;
    logic scan_step;
    logic emit_read;
  } ctl_cmd_t;

  typedef struct packed {
    logic req_read;
    logic scan_hit;
    logic scan_last;
  } ctl_stat_t;

endpackage

@@ rtl/adcss_ctrl.sv @@
module adcss_ctrl
  import adcss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd,
  output logic      busy,
  output logic      out_valid
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SVC  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = stat.req_read ? S_SCAN : S_SVC;
        end
      end
      S_SVC: begin
        cmd.do_svc = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_last) begin
          cmd.emit_read = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = cmd.do_svc | cmd.emit_read;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ rtl/adcss_dp.sv @@
module adcss_dp
  import adcss_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_req_t              in_data,
  input  ctl_cmd_t             cmd,
  output ctl_stat_t            stat,
  output out_res_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

  logic                  enabled_r;
  logic [CNT_CFG_W-1:0]  ch_count_r;
  logic [TIME_WIDTH-1:0] timeout_r;
  logic [TIME_WIDTH-1:0] max_age_r;
  logic [CFG_W-1:0]      probe_map_r;

  logic                  converting_r, converting_nxt;
  logic [CH_W-1:0]       active_r, active_nxt;
  logic [CH_W-1:0]       next_r, next_nxt;
  logic [TIME_WIDTH-1:0] deadline_r, deadline_nxt;
  logic [CH_W-1:0]       scan_r;
  logic [MAX_CHANNELS-1:0] present_r;

  logic signed [TEMP_WIDTH-1:0] sample_value [MAX_CHANNELS];
  logic [TIME_WIDTH-1:0]        sample_time  [MAX_CHANNELS];

  in_req_t  req_r;
  out_res_t out_r;

  logic [CNT_CFG_W:0]    cc_ext;
  logic [CNT_W-1:0]      eff_n;
  logic [CH_W-1:0]       sel_idx;
  logic [TIME_WIDTH:0]   dl_sum;
  logic [EV_W-1:0]       svc_ev;
  logic                  wr_clear, wr_store;
  logic [PROBE_W-1:0]    scan_probe;
  logic [TIME_WIDTH-1:0] scan_time, scan_age;
  logic                  scan_fresh;

  function automatic logic [CH_W-1:0] adv_idx(input logic [CH_W-1:0] a,
                                               input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] a1;
    a1 = CNT_W'(a) + CNT_W'(1);
    return (a1 < n) ? CH_W'(a1) : '0;
  endfunction

  always_comb begin
    cc_ext = {1'b0, ch_count_r};
    if (cc_ext == '0) begin
      eff_n = CNT_W'(1);
    end else if (cc_ext > (CNT_CFG_W + 1)'(MAX_CHANNELS)) begin
      eff_n = CNT_W'(MAX_CHANNELS);
    end else begin
      eff_n = CNT_W'(cc_ext);
    end
  end

  always_comb begin
    sel_idx        = (CNT_W'(next_r) < eff_n) ? next_r : '0;
    dl_sum         = {1'b0, req_r.now} + {1'b0, timeout_r};
    converting_nxt = converting_r;
    active_nxt     = active_r;
    next_nxt       = next_r;
    deadline_nxt   = deadline_r;
    wr_clear       = 1'b0;
    wr_store       = 1'b0;
    svc_ev         = EV_IDLE;
    if (enabled_r) begin
      if (!converting_r) begin
        active_nxt = sel_idx;
        if (!req_r.start_ok) begin
          wr_clear = 1'b1;
          next_nxt = adv_idx(sel_idx, eff_n);
          svc_ev   = EV_FAILED;
        end else begin
          deadline_nxt   = dl_sum[TIME_WIDTH] ? '1 : dl_sum[TIME_WIDTH-1:0];
          converting_nxt = 1'b1;
          svc_ev         = EV_STARTED;
        end
      end else if (req_r.now >= deadline_r || !req_r.poll_ok || (!req_r.busy_req &&
                   !req_r.value_ok)) begin
        wr_clear       = 1'b1;
        next_nxt       = adv_idx(active_r, eff_n);
        converting_nxt = 1'b0;
        svc_ev         = EV_FAILED;
      end else if (!req_r.busy_req) begin
        wr_store       = req_r.convert_ok;
        wr_clear       = !req_r.convert_ok;
        next_nxt       = adv_idx(active_r, eff_n);
        converting_nxt = 1'b0;
        svc_ev         = req_r.convert_ok ? EV_STORED : EV_CLEARED;
      end
    end
  end

  always_comb begin
    scan_probe     = (32'(scan_r) < 32'(PROBE_SLOTS)) ?
                     PROBE_W'(probe_map_r >> {scan_r, 2'b00}) : '0;
    scan_time      = sample_time[scan_r];
    scan_age       = req_r.now - scan_time;
    scan_fresh     = (req_r.now >= scan_time) && (scan_age <= max_age_r);
    stat.req_read  = in_data.cmd;
    stat.scan_hit  = (scan_probe == req_r.probe_sel) && present_r[scan_r];
    stat.scan_last = ((CNT_W'(scan_r) + CNT_W'(1)) == eff_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r    <= 1'b0;
      ch_count_r   <= CNT_CFG_W'(1);
      timeout_r    <= TIME_WIDTH'(1000);
      max_age_r    <= TIME_WIDTH'(5000);
      probe_map_r  <= '0;
      converting_r <= 1'b0;
      active_r     <= '0;
      next_r       <= '0;
      deadline_r   <= '0;
      scan_r       <= '0;
      present_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ENABLED:   enabled_r   <= cfg_wdata[0];
          CFG_CH_COUNT:  ch_count_r  <= cfg_wdata[CNT_CFG_W-1:0];
          CFG_TIMEOUT:   timeout_r   <= TIME_WIDTH'(cfg_wdata);
          CFG_MAX_AGE:   max_age_r   <= TIME_WIDTH'(cfg_wdata);
          CFG_PROBE_MAP: probe_map_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.load) begin
        scan_r <= '0;
      end else if (cmd.scan_step) begin
        scan_r <= scan_r + CH_W'(1);
      end
      if (cmd.do_svc) begin
        converting_r <= converting_nxt;
        active_r     <= active_nxt;
        next_r       <= next_nxt;
        deadline_r   <= deadline_nxt;
        if (wr_clear) present_r[active_nxt] <= 1'b0;
        if (wr_store) present_r[active_nxt] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.do_svc && wr_store) begin
      sample_value[active_nxt] <= req_r.temperature;
      sample_time[active_nxt]  <= req_r.now;
    end
    if (cmd.do_svc) begin
      out_r.event_res        <= svc_ev;
      out_r.channel          <= CH_OUT_W'(active_nxt);
      out_r.read_valid       <= 1'b0;
      out_r.read_temperature <= '0;
    end else if (cmd.emit_read) begin
      out_r.event_res <= EV_READ;
      if (stat.scan_hit) begin
        out_r.channel          <= CH_OUT_W'(scan_r);
        out_r.read_valid       <= scan_fresh;
        out_r.read_temperature <= scan_fresh ? sample_value[scan_r] : '0;
      end else begin
        out_r.channel          <= '0;
        out_r.read_valid       <= 1'b0;
        out_r.read_temperature <= '0;
      end
    end
  end

  assign out_data = out_r;

endmodule

@@ rtl/adc_scan_sequencer_with_sample_cache_core.sv @@
// Channel   Ports                           Moves
// input     start, busy, in_data            one request, taken when start and !busy
// result    out_valid, out_data             one result per request, one-cycle strobe
// config    cfg_we, cfg_index, cfg_wdata    one register write per cycle, no wait
//
// A service request passes through the S_SVC state and then the registered result strobe;
// the next request is taken in the cycle the strobe shows.
// A read walks the cache one channel a cycle through the single compare unit on
// the scan path and stops at the first hit or at the last configured channel.
// Reset is synchronous, active low; it clears the cache present bits at once.
// Results cannot be stalled.
module adc_scan_sequencer_with_sample_cache_core
  import adcss_pkg::*;
#(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_req_t              in_data,
  output logic                 out_valid,
  output out_res_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  ctl_cmd_t  cmd;
  ctl_stat_t stat;

  adcss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  adcss_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_read_valid_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.read_valid) |-> (out_data.event_res == EV_READ))
    else $error("read_valid on a service result");

  a_read_temp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.read_valid) |-> (out_data.read_temperature == '0))
    else $error("temperature returned without a valid sample");

endmodule

@@ dv/adc_scan_sequencer_with_sample_cache_core_test.sv @@
module adc_scan_sequencer_with_sample_cache_core_test
  import adcss_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_SERVICE = 1'b0;
  localparam logic CMD_READ    = 1'b1;
  localparam int   NCH          = MAX_CHANNELS_DEF;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   SETTLE_CYCLES  = 12;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_req_t              in_data;
  logic                 out_valid;
  out_res_t             out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  adc_scan_sequencer_with_sample_cache_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic                         reg_enabled;
  logic [CNT_CFG_W-1:0]         reg_count;
  logic [TIME_WIDTH-1:0]        reg_timeout;
  logic [TIME_WIDTH-1:0]        reg_max_age;
  logic [CFG_W-1:0]             reg_probe_map;

  logic                         conv_busy;
  logic [2:0]                   scan_active;
  logic [2:0]                   scan_next;
  logic [TIME_WIDTH-1:0]        conv_deadline;
  logic                         cache_valid [NCH];
  logic signed [TEMP_WIDTH-1:0] cache_temp  [NCH];
  logic [TIME_WIDTH-1:0]        cache_stamp [NCH];

  out_res_t              expected_results [$];
  out_res_t              oldest;
  logic [TIME_WIDTH-1:0] tick_now;
  int                    fail_count;
  int                    idle_cycles;
  int                    req_count;
  int                    checked_count;
  int                    stored_count;
  int                    fresh_read_count;

  function automatic int scan_length();
    if (reg_count == 0) return 1;
    if (reg_count > NCH) return NCH;
    return int'(reg_count);
  endfunction

  function automatic void advance_scan();
    scan_next = (int'(scan_active) + 1 < scan_length()) ? scan_active + 3'd1 : 3'd0;
    conv_busy = 1'b0;
  endfunction

  function automatic out_res_t predict_result(input in_req_t r);
    out_res_t res;
    int       n;
    logic     found;
    n = scan_length();
    found = 1'b0;
    res = '0;
    if (r.cmd == CMD_READ) begin
      res.event_res = EV_READ;
      for (int i = 0; i < n; i++) begin
        if (!found && reg_probe_map[4*i +: 4] == r.probe_sel && cache_valid[i]) begin
          found = 1'b1;
          res.channel = i[2:0];
          if (!(r.now < cache_stamp[i] || (r.now - cache_stamp[i]) > reg_max_age)) begin
            res.read_valid = 1'b1;
            res.read_temperature = cache_temp[i];
          end
        end
      end
      return res;
    end
    if (!reg_enabled) begin
      res.event_res = EV_IDLE;
    end else if (!conv_busy) begin
      scan_active = (int'(scan_next) < n) ? scan_next : 3'd0;
      if (!r.start_ok) begin
        cache_valid[scan_active] = 1'b0;
        advance_scan();
        res.event_res = EV_FAILED;
      end else begin
        conv_deadline = (reg_timeout > ~r.now) ? '1 : r.now + reg_timeout;
        conv_busy = 1'b1;
        res.event_res = EV_STARTED;
      end
    end else if (r.now >= conv_deadline || !r.poll_ok) begin
      cache_valid[scan_active] = 1'b0;
      advance_scan();
      res.event_res = EV_FAILED;
    end else if (r.busy_req) begin
      res.event_res = EV_IDLE;
    end else if (!r.value_ok) begin
      cache_valid[scan_active] = 1'b0;
      advance_scan();
      res.event_res = EV_FAILED;
    end else begin
      if (r.convert_ok) begin
        cache_temp[scan_active]  = r.temperature;
        cache_stamp[scan_active] = r.now;
        cache_valid[scan_active] = 1'b1;
        res.event_res = EV_STORED;
      end else begin
        cache_valid[scan_active] = 1'b0;
        res.event_res = EV_CLEARED;
      end
      advance_scan();
    end
    res.channel = scan_active;
    return res;
  endfunction

  function automatic in_req_t noise_req();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(in_req_t)-1:0];
  endfunction

  function automatic in_req_t svc_req(logic [TIME_WIDTH-1:0] t, logic s_ok, logic p_ok,
                                      logic bsy, logic v_ok, logic c_ok,
                                      logic [TEMP_WIDTH-1:0] temp);
    in_req_t r;
    r = noise_req();
    r.cmd = CMD_SERVICE;
    r.now = t;
    r.start_ok = s_ok;
    r.poll_ok = p_ok;
    r.busy_req = bsy;
    r.value_ok = v_ok;
    r.convert_ok = c_ok;
    r.temperature = temp;
    return r;
  endfunction

  function automatic in_req_t rd_req(logic [TIME_WIDTH-1:0] t, logic [PROBE_W-1:0] probe);
    in_req_t r;
    r = noise_req();
    r.cmd = CMD_READ;
    r.now = t;
    r.probe_sel = probe;
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] shared_probe_map();
    logic [CFG_W-1:0] ids;
    for (int i = 0; i < NCH; i++) ids[4*i +: 4] = 4'($urandom_range(0, 3));
    return ids;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch: %s got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("adc_scan_sequencer_with_sample_cache_core_test: FAIL");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request", 32'(out_data), 32'hx);
      end else begin
        oldest = expected_results.pop_front();
        checked_count++;
        if (out_data.event_res !== oldest.event_res)
          report_mismatch("event_res", 32'(out_data.event_res), 32'(oldest.event_res));
        if (out_data.channel !== oldest.channel)
          report_mismatch("channel", 32'(out_data.channel), 32'(oldest.channel));
        if (out_data.read_valid !== oldest.read_valid)
          report_mismatch("read_valid", 32'(out_data.read_valid), 32'(oldest.read_valid));
        if (out_data.read_temperature !== oldest.read_temperature)
          report_mismatch("read_temperature", 32'(unsigned'(out_data.read_temperature)),
                          32'(unsigned'(oldest.read_temperature)));
      end
    end
  end

  task automatic send_req(input in_req_t r);
    out_res_t want;
    start   <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (busy);
    want = predict_result(r);
    expected_results.push_back(want);
    req_count++;
    if (want.event_res == EV_STORED) stored_count++;
    if (want.read_valid) fresh_read_count++;
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ENABLED:   reg_enabled   = val[0];
      CFG_CH_COUNT:  reg_count     = val[CNT_CFG_W-1:0];
      CFG_TIMEOUT:   reg_timeout   = val;
      CFG_MAX_AGE:   reg_max_age   = val;
      CFG_PROBE_MAP: reg_probe_map = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_after_reset();
    send_req(svc_req(32'd5, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h1234));
    send_req(rd_req(32'd5, 4'h0));
  endtask

  task automatic test_conversion_paths();
    write_reg(CFG_ENABLED, 32'd1);
    write_reg(CFG_CH_COUNT, 32'd3);
    write_reg(CFG_TIMEOUT, 32'd100);
    write_reg(CFG_MAX_AGE, 32'd50);
    write_reg(CFG_PROBE_MAP, 32'h0000_0321);
    send_req(svc_req(32'd10,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0001));
    send_req(svc_req(32'd20,  1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'h0002));
    send_req(svc_req(32'd30,  1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 16'h0003));
    send_req(svc_req(32'd40,  1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0004));
    send_req(svc_req(32'd50,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0005));
    send_req(svc_req(32'd60,  1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 16'h0006));
    send_req(svc_req(32'd70,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0007));
    send_req(svc_req(32'd80,  1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'h0008));
    send_req(svc_req(32'd90,  1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0009));
    send_req(svc_req(32'd190, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'h000a));
    send_req(svc_req(32'd200, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h000b));
    send_req(svc_req(32'd210, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h7fff));
    send_req(svc_req(32'd220, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h000c));
    send_req(svc_req(32'd230, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h8000));
  endtask

  task automatic test_sample_reads();
    send_req(rd_req(32'd260, 4'h3));
    send_req(rd_req(32'd261, 4'h3));
    send_req(rd_req(32'd229, 4'h1));
    send_req(rd_req(32'd230, 4'h1));
  endtask

  task automatic test_index_limits();
    write_reg(CFG_CH_COUNT, 32'd0);
    send_req(svc_req(32'd300, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0101));
    send_req(svc_req(32'd310, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'hfefe));
    write_reg(CFG_CH_COUNT, 32'd15);
    write_reg(CFG_TIMEOUT, 32'hffff_ffff);
    send_req(svc_req(32'd320, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0000));
    send_req(svc_req(32'd330, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0000));
    send_req(svc_req(32'hffff_ff00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h0000));
    write_reg(CFG_CH_COUNT, 32'd2);
    send_req(svc_req(32'hffff_fffe, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 16'h5a5a));
  endtask

  task automatic run_scan_phase(int n_req, logic en, logic [CNT_CFG_W-1:0] cnt,
                                logic [TIME_WIDTH-1:0] tmo, logic [TIME_WIDTH-1:0] age,
                                logic [CFG_W-1:0] ids, logic [TIME_WIDTH-1:0] t0,
                                int step_max);
    in_req_t r;
    int      burst_left;
    write_reg(CFG_ENABLED, 32'(en));
    write_reg(CFG_CH_COUNT, 32'(cnt));
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_MAX_AGE, age);
    write_reg(CFG_PROBE_MAP, ids);
    tick_now = t0;
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < n_req; i++) begin
      r = noise_req();
      if ($urandom_range(0, 31) != 0) begin
        tick_now = tick_now + 32'($urandom_range(0, step_max));
        r.now = tick_now;
      end
      if ($urandom_range(0, 9) < 3) begin
        r.cmd = CMD_READ;
        if ($urandom_range(0, 3) != 0)
          r.probe_sel = reg_probe_map[4*$urandom_range(0, scan_length() - 1) +: 4];
      end else begin
        r.cmd        = CMD_SERVICE;
        r.start_ok   = ($urandom_range(0, 7) != 0);
        r.poll_ok    = ($urandom_range(0, 15) != 0);
        r.busy_req   = ($urandom_range(0, 3) == 0);
        r.value_ok   = ($urandom_range(0, 15) != 0);
        r.convert_ok = ($urandom_range(0, 7) != 0);
      end
      send_req(r);
      if (i == n_req / 2) begin
        wait_drained();
      end else if (--burst_left <= 0) begin
        burst_left = $urandom_range(1, 16);
        hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
      end
    end
  endtask

  task automatic test_random_scan();
    run_scan_phase(260, 1'b1, 4'd8, $urandom_range(20, 200), $urandom_range(50, 2000),
                   $urandom, $urandom_range(0, 65535), 30);
    run_scan_phase(200, 1'b1, 4'd1, 32'd1, 32'd1, 32'd0, 32'd0, 2);
    run_scan_phase(260, 1'b1, 4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                   32'hffff_0000, 30);
    run_scan_phase(260, 1'b1, 4'd0, $urandom_range(1, 60), $urandom_range(1, 100),
                   shared_probe_map(), $urandom, 20);
    run_scan_phase(60, 1'b0, 4'($urandom_range(1, 8)), $urandom_range(1, 100),
                   $urandom_range(1, 100), $urandom, $urandom, 10);
    run_scan_phase(390, 1'b1, 4'($urandom_range(2, 8)), $urandom_range(10, 400),
                   $urandom_range(20, 600), shared_probe_map(), $urandom, 25);
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_ENABLED;
    cfg_wdata <= '0;
    reg_enabled   = 1'b0;
    reg_count     = 4'd1;
    reg_timeout   = 32'd1000;
    reg_max_age   = 32'd5000;
    reg_probe_map = '0;
    conv_busy     = 1'b0;
    scan_active   = 3'd0;
    scan_next     = 3'd0;
    conv_deadline = '0;
    for (int i = 0; i < NCH; i++) begin
      cache_valid[i] = 1'b0;
      cache_temp[i]  = '0;
      cache_stamp[i] = '0;
    end
    fail_count       = 0;
    idle_cycles      = 0;
    req_count        = 0;
    checked_count    = 0;
    stored_count     = 0;
    fresh_read_count = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_conversion_paths();
    test_sample_reads();
    test_index_limits();
    test_random_scan();
    wait_drained();
    $display("covered %0d requests over six scan settings, %0d results checked",
             req_count, checked_count);
    $display("samples stored %0d, fresh reads %0d, mismatches %0d",
             stored_count, fresh_read_count, fail_count);
    if (fail_count == 0) begin
      $display("adc_scan_sequencer_with_sample_cache_core_test: PASS");
    end else begin
      $display("adc_scan_sequencer_with_sample_cache_core_test: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/adcss_pkg.sv
rtl/adcss_ctrl.sv
rtl/adcss_dp.sv
rtl/adc_scan_sequencer_with_sample_cache_core.sv
dv/adc_scan_sequencer_with_sample_cache_core_test.sv
